/* rtl/rwgs_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and controller command type for the water ripple grid step unit
package rwgs_pkg;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int NCELLS    = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(NCELLS);
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);

	localparam int DATA_W    = 24;
	localparam int PX_W      = 10;
	localparam int STEP_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 32;

	localparam logic [STEP_W-1:0] PRESS_LAST = 3'd3;
	localparam logic [STEP_W-1:0] LAP_LAST   = 3'd6;
	localparam logic [STEP_W-1:0] UPD_LAST   = 3'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS   = 2'd2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [15:0]       BLUR_RST  = 16'd983;
	localparam logic [DATA_W-1:0] PRESS_RST = 24'hFFE200;

	typedef struct packed {
		logic              load;
		logic              clr;
		logic              press;
		logic              lap;
		logic              upd;
		logic              fin;
		logic [ADDR_W-1:0] clr_addr;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [STEP_W-1:0] step;
	} cmd_t;

endpackage

/* rtl/rwgs_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module rwgs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/rwgs_datapath.sv */
`timescale 1ns / 1ps
// datapath: config registers, grid memories, stencil and update arithmetic, result register
module rwgs_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rwgs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rwgs_pkg::CFG_W-1:0]        cfg_data,
	input  logic [rwgs_pkg::IN_TDATA_W-1:0]   in_data,
	input  logic                              in_op,
	input  rwgs_pkg::cmd_t                    cmd,
	output logic                              enabled,
	output logic [rwgs_pkg::OUT_TDATA_W-1:0]  out_data,
	output logic                              out_kind
);
	import rwgs_pkg::*;

	localparam int ACC_W  = 28;
	localparam int SUM_W  = 29;
	localparam int PROD_W = 41;
	localparam int PXP_W  = PX_W + COL_W;
	localparam int PYP_W  = PX_W + ROW_W;
	localparam int RA_W   = 16;

	function automatic logic signed [DATA_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SUM_W'(8388607)) r = 24'sh7FFFFF;
		else if (v < -SUM_W'(8388608)) r = 24'sh800000;
		else r = DATA_W'(v);
		return r;
	endfunction

	function automatic logic ovf24(input logic signed [SUM_W-1:0] v);
		return (v > SUM_W'(8388607)) || (v < -SUM_W'(8388608));
	endfunction

	logic                     enabled_q;
	logic [15:0]              blur_q;
	logic [DATA_W-1:0]        press_q;

	logic                     op_q;
	logic [15:0]              dt_q;
	logic [ADDR_W-1:0]        rd_addr_q;
	logic                     rd_ok_q;
	logic [ROW_W-1:0]         ay_q;
	logic [COL_W-1:0]         ax_q;
	logic                     applied_q;
	logic                     sat_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] p_dv_s1;
	logic signed [PROD_W-1:0] p_bl_s1;
	logic signed [DATA_W-1:0] h_s1;
	logic [OUT_TDATA_W-1:0]   out_q;
	logic                     kind_q;

	// item fields, lowest bit first
	logic [15:0]      f_dt;
	logic             f_pressed;
	logic [PX_W-1:0]  f_px;
	logic [PX_W-1:0]  f_py;
	logic [5:0]       f_rr;
	logic [5:0]       f_rc;
	assign f_dt      = in_data[15:0];
	assign f_pressed = in_data[16];
	assign f_px      = in_data[26:17];
	assign f_py      = in_data[36:27];
	assign f_rr      = in_data[42:37];
	assign f_rc      = in_data[48:43];

	// pointer to cell mapping
	logic [PXP_W-1:0] px_prod;
	logic [PYP_W-1:0] py_prod;
	logic [COL_W-1:0] ax;
	logic [ROW_W-1:0] ay;
	logic             press_ok;
	logic [RA_W-1:0]  rd_addr_full;
	assign px_prod = PXP_W'(f_px) * PXP_W'(GRID_COLS - 1);
	assign py_prod = PYP_W'(f_py) * PYP_W'(GRID_ROWS - 1);
	assign ax = COL_W'(px_prod >> PX_W);
	assign ay = ROW_W'(py_prod >> PX_W);
	assign press_ok = enabled_q && f_pressed && (in_op == OP_TICK)
		&& (ax > COL_W'(1)) && (ax < COL_W'(GRID_COLS - 1))
		&& (ay > ROW_W'(1)) && (ay < ROW_W'(GRID_ROWS - 1));
	assign rd_addr_full = RA_W'(f_rr) * RA_W'(GRID_COLS) + RA_W'(f_rc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			blur_q    <= BLUR_RST;
			press_q   <= PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data[0];
				CFG_BLUR:    blur_q    <= cfg_data[15:0];
				CFG_PRESS:   press_q   <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end
	assign enabled = enabled_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_op;
			dt_q      <= f_dt;
			rd_addr_q <= ADDR_W'(rd_addr_full);
			rd_ok_q   <= (9'(f_rr) < 9'(GRID_ROWS)) && (9'(f_rc) < 9'(GRID_COLS));
			ax_q      <= ax;
			ay_q      <= ay;
		end
	end

	// cell addresses
	logic [ADDR_W-1:0] k;
	logic [ROW_W:0]    st_row;
	logic [COL_W:0]    st_col;
	logic              st_in;
	logic [ADDR_W-1:0] st_addr;
	assign k = ADDR_W'(cmd.row) * ADDR_W'(GRID_COLS) + ADDR_W'(cmd.col);
	assign st_row = (ROW_W+1)'(ay_q) + (ROW_W+1)'(cmd.step[1]);
	assign st_col = (COL_W+1)'(ax_q) + (COL_W+1)'(cmd.step[0]);
	assign st_in = (st_row < (ROW_W+1)'(GRID_ROWS - 1)) && (st_col < (COL_W+1)'(GRID_COLS - 1));
	assign st_addr = ADDR_W'(st_row) * ADDR_W'(GRID_COLS) + ADDR_W'(st_col);

	logic signed [DATA_W-1:0] h_rd, v_rd, l_rd;
	logic              h_we, v_we, l_we;
	logic [ADDR_W-1:0] h_waddr, h_raddr, vl_waddr;
	logic [DATA_W-1:0] h_wdata, v_wdata, l_wdata;

	// lap finish and height update arithmetic
	logic signed [DATA_W-1:0] lap_new, v_new, h_new;
	logic signed [SUM_W-1:0]  v_sum, h_sum, dv, bl;
	logic                     lap_ovf, v_ovf, h_ovf;
	assign lap_new = sat24(SUM_W'(acc_q));
	assign lap_ovf = ovf24(SUM_W'(acc_q));
	assign v_sum   = SUM_W'(v_rd) + SUM_W'(lap_new);
	assign v_new   = sat24(v_sum);
	assign v_ovf   = ovf24(v_sum);
	// round half up: add one half then floor
	assign dv    = SUM_W'((p_dv_s1 + PROD_W'(32768)) >>> 16);
	assign bl    = SUM_W'((p_bl_s1 + PROD_W'(32768)) >>> 16);
	assign h_sum = SUM_W'(h_s1) + (dv <<< 1) + bl;
	assign h_new = sat24(h_sum);
	assign h_ovf = ovf24(h_sum);

	always_comb begin
		h_raddr  = rd_addr_q;
		h_we     = 1'b0;
		h_waddr  = k;
		h_wdata  = h_new;
		v_we     = 1'b0;
		l_we     = 1'b0;
		vl_waddr = k;
		v_wdata  = v_new;
		l_wdata  = lap_new;
		if (cmd.clr) begin
			h_we     = 1'b1;
			v_we     = 1'b1;
			l_we     = 1'b1;
			h_waddr  = cmd.clr_addr;
			vl_waddr = cmd.clr_addr;
			h_wdata  = '0;
			v_wdata  = '0;
			l_wdata  = '0;
		end else if (cmd.press) begin
			h_we    = applied_q && st_in;
			h_waddr = st_addr;
			h_wdata = press_q;
		end else if (cmd.lap) begin
			case (cmd.step)
				3'd1:    h_raddr = k - ADDR_W'(1);
				3'd2:    h_raddr = k + ADDR_W'(1);
				3'd3:    h_raddr = k - ADDR_W'(GRID_COLS);
				3'd4:    h_raddr = k + ADDR_W'(GRID_COLS);
				default: h_raddr = k;
			endcase
			v_we = (cmd.step == LAP_LAST);
			l_we = (cmd.step == LAP_LAST);
		end else if (cmd.upd) begin
			h_raddr = k;
			h_we    = (cmd.step == UPD_LAST);
		end
	end

	rwgs_ram #(.WIDTH(DATA_W), .DEPTH(NCELLS)) u_h_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rd)
	);
	rwgs_ram #(.WIDTH(DATA_W), .DEPTH(NCELLS)) u_v_ram (
		.clk(clk), .we(v_we), .waddr(vl_waddr), .wdata(v_wdata),
		.raddr(k), .rdata(v_rd)
	);
	rwgs_ram #(.WIDTH(DATA_W), .DEPTH(NCELLS)) u_l_ram (
		.clk(clk), .we(l_we), .waddr(vl_waddr), .wdata(l_wdata),
		.raddr(k), .rdata(l_rd)
	);

	// stencil accumulator, data arrives in the cycle after its address
	always_ff @(posedge clk) begin
		if (cmd.lap) begin
			case (cmd.step)
				3'd1:                   acc_q <= -(ACC_W'(h_rd) <<< 2);
				3'd2, 3'd3, 3'd4, 3'd5: acc_q <= acc_q + ACC_W'(h_rd);
				default: ;
			endcase
		end
		if (cmd.upd && cmd.step == 3'd1) begin
			p_dv_s1 <= PROD_W'($signed({1'b0, dt_q})) * PROD_W'(v_rd);
			p_bl_s1 <= PROD_W'($signed({1'b0, blur_q})) * PROD_W'(l_rd);
			h_s1    <= h_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q <= 1'b0;
			sat_q     <= 1'b0;
		end else if (cmd.load) begin
			applied_q <= press_ok;
			sat_q     <= 1'b0;
		end else if (cmd.lap && cmd.step == LAP_LAST) begin
			sat_q <= sat_q | lap_ovf | v_ovf;
		end else if (cmd.upd && cmd.step == UPD_LAST) begin
			sat_q <= sat_q | h_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			kind_q <= op_q;
			out_q  <= {6'd0, sat_q, applied_q,
				(op_q == OP_READ && rd_ok_q) ? h_rd : {DATA_W{1'b0}}};
		end
	end

	assign out_data = out_q;
	assign out_kind = kind_q;

endmodule

/* rtl/rwgs_ctrl.sv */
`timescale 1ns / 1ps
// controller: clearing pass, tick sequencing over the grid, handshakes
module rwgs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	input  logic            s_op,
	input  logic            enabled,
	input  logic            m_ready,
	output logic            s_ready,
	output logic            m_valid,
	output rwgs_pkg::cmd_t  cmd
);
	import rwgs_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_READ   = 7'b0000100,
		S_PRESS  = 7'b0001000,
		S_LAP    = 7'b0010000,
		S_UPD    = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [STEP_W-1:0] step_q;
	logic              m_valid_q;

	logic load, fin, last_cell;
	assign load = (state_q == S_IDLE) && s_valid;
	assign fin  = (state_q == S_FINISH) && (!m_valid_q || m_ready);
	assign last_cell = (row_q == ROW_W'(GRID_ROWS - 2)) && (col_q == COL_W'(GRID_COLS - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			row_q     <= ROW_W'(1);
			col_q     <= COL_W'(1);
			step_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(NCELLS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					step_q <= '0;
					row_q  <= ROW_W'(1);
					col_q  <= COL_W'(1);
					if (s_valid) begin
						if (s_op == OP_READ) state_q <= S_READ;
						else if (enabled) state_q <= S_PRESS;
						else state_q <= S_FINISH;
					end
				end
				S_READ: state_q <= S_FINISH;
				S_PRESS: begin
					if (step_q == PRESS_LAST) begin
						step_q  <= '0;
						state_q <= S_LAP;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_LAP, S_UPD: begin
					if (step_q == ((state_q == S_LAP) ? LAP_LAST : UPD_LAST)) begin
						step_q <= '0;
						if (last_cell) begin
							row_q   <= ROW_W'(1);
							col_q   <= COL_W'(1);
							state_q <= (state_q == S_LAP) ? S_UPD : S_FINISH;
						end else if (col_q == COL_W'(GRID_COLS - 2)) begin
							col_q <= COL_W'(1);
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_FINISH: if (fin) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd.load     = load;
		cmd.clr      = (state_q == S_CLEAR);
		cmd.press    = (state_q == S_PRESS);
		cmd.lap      = (state_q == S_LAP);
		cmd.upd      = (state_q == S_UPD);
		cmd.fin      = fin;
		cmd.clr_addr = clr_cnt_q;
		cmd.row      = row_q;
		cmd.col      = col_q;
		cmd.step     = step_q;
	end

	assign s_ready = (state_q == S_IDLE);
	assign m_valid = m_valid_q;

endmodule

/* rtl/water_ripple_grid_step_unit.sv */
`timescale 1ns / 1ps
// top level of the water ripple grid step unit
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tick or read request
//  m_*      out  m_tvalid/m_tready  tick done or read height
//  cfg_*    in   cfg_we             enabled, blur_gain, press_height
//
// after reset a clearing pass zeroes all three grids, one cell a cycle, with
// s_tready low; config writes are taken during it
// a read passes through the read state; a disabled tick goes straight to finish
// an enabled tick runs the press steps, then a stencil sweep over interior cells
// paced by the single height read port, then an update sweep; m_tready low holds the
// result and the unit waits before its next beat
module water_ripple_grid_step_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// time_step[15:0], pressed[16], pointer_x[26:17], pointer_y[36:27],
	// read_row[42:37], read_col[48:43], zero fill
	input  logic [rwgs_pkg::IN_TDATA_W-1:0]     s_tdata,
	// op
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// height[23:0], press_applied[24], saturated[25], zero fill
	output logic [rwgs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// kind
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [rwgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rwgs_pkg::CFG_W-1:0]          cfg_data
);
	import rwgs_pkg::*;

	cmd_t cmd;
	logic enabled;

	rwgs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_tvalid), .s_op(s_tuser), .enabled(enabled), .m_ready(m_tready),
		.s_ready(s_tready), .m_valid(m_tvalid), .cmd(cmd)
	);

	rwgs_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_data(s_tdata), .in_op(s_tuser), .cmd(cmd), .enabled(enabled),
		.out_data(m_tdata), .out_kind(m_tuser)
	);

endmodule

/* bench/tb_water_ripple_grid_step_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench for the water ripple grid step unit
module tb_water_ripple_grid_step_unit;
	import rwgs_pkg::*;

	localparam int VMAX = 8388607;
	localparam int VMIN = -8388608;

	typedef struct {
		logic        op;
		logic [15:0] dt;
		logic        pressed;
		logic [9:0]  px;
		logic [9:0]  py;
		logic [5:0]  rr;
		logic [5:0]  rc;
	} request_t;

	typedef struct {
		logic        kind;
		logic [23:0] height;
		logic        applied;
		logic        sat;
	} answer_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	water_ripple_grid_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// local copy of the grid state and registers
	int  wave_h[NCELLS];
	int  wave_v[NCELLS];
	int  wave_lap[NCELLS];
	bit  ripple_on;
	int  blur_q16;
	int  stamp_height;

	request_t request_q[$];
	answer_t  answer_q[$];
	request_t offered;
	int       mismatch_count;
	int       answers_seen;
	int       burst_left;
	int       gap_left;
	int       hold_left;
	bit       hold_done;
	int       stall_mode_left;
	bit       stall_mode;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int clip24(longint v, inout bit flag);
		if (v > VMAX) begin
			flag = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			flag = 1'b1;
			return VMIN;
		end
		return int'(v);
	endfunction

	// round half up of p / 2^16
	function automatic longint round_q16(longint p);
		return (p + 32768) >>> 16;
	endfunction

	function automatic answer_t step_grid(request_t rq);
		answer_t a;
		bit      sat;
		int      ax;
		int      ay;
		int      k;
		longint  l;
		longint  dv;
		longint  bl;
		sat = 1'b0;
		a.kind = rq.op;
		a.height = '0;
		a.applied = 1'b0;
		if (rq.op == OP_READ) begin
			a.height = wave_h[rq.rr * GRID_COLS + rq.rc][23:0];
		end else if (ripple_on) begin
			if (rq.pressed) begin
				ax = (int'(rq.px) * (GRID_COLS - 1)) >> 10;
				ay = (int'(rq.py) * (GRID_ROWS - 1)) >> 10;
				if (ax > 1 && ax < GRID_COLS - 1 && ay > 1 && ay < GRID_ROWS - 1) begin
					a.applied = 1'b1;
					wave_h[ay * GRID_COLS + ax] = stamp_height;
					if (ay + 1 < GRID_ROWS - 1)
						wave_h[(ay + 1) * GRID_COLS + ax] = stamp_height;
					if (ax + 1 < GRID_COLS - 1)
						wave_h[ay * GRID_COLS + ax + 1] = stamp_height;
					if (ay + 1 < GRID_ROWS - 1 && ax + 1 < GRID_COLS - 1)
						wave_h[(ay + 1) * GRID_COLS + ax + 1] = stamp_height;
				end
			end
			for (int i = 1; i < GRID_ROWS - 1; i++)
				for (int j = 1; j < GRID_COLS - 1; j++) begin
					k = i * GRID_COLS + j;
					l = -4 * longint'(wave_h[k]) + wave_h[k + GRID_COLS]
						+ wave_h[k - GRID_COLS] + wave_h[k + 1] + wave_h[k - 1];
					wave_lap[k] = clip24(l, sat);
					wave_v[k] = clip24(longint'(wave_v[k]) + wave_lap[k], sat);
				end
			for (int i = 1; i < GRID_ROWS - 1; i++)
				for (int j = 1; j < GRID_COLS - 1; j++) begin
					k = i * GRID_COLS + j;
					dv = round_q16(longint'(rq.dt) * wave_v[k]);
					bl = round_q16(longint'(blur_q16) * wave_lap[k]);
					wave_h[k] = clip24(longint'(wave_h[k]) + 2 * dv + bl, sat);
				end
		end
		a.sat = (rq.op == OP_READ) ? 1'b0 : sat;
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h (beat %0d)", what, got, want,
			answers_seen);
		mismatch_count++;
	endtask

	// sender: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				answer_q.push_back(step_grid(offered));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (request_q.size() > 0) begin
					offered = request_q.pop_front();
					s_tdata <= {7'b0, offered.rc, offered.rr, offered.py, offered.px,
						offered.pressed, offered.dt};
					s_tuser <= offered.op;
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: alternating stretches of free flow and random stalls, plus one long hold
	// the long hold outlasts two enabled ticks so the unit always ends up stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_mode_left == 0) begin
				stall_mode_left = $urandom_range(16, 96);
				stall_mode = $urandom_range(0, 1);
			end else begin
				stall_mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && answers_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = 80000;
				m_tready <= 1'b0;
			end else begin
				m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (answer_q.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 32'h0);
			end else begin
				want = answer_q.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", m_tuser, want.kind);
				if (m_tdata[23:0] !== want.height)
					report_mismatch("height", m_tdata[23:0], want.height);
				if (m_tdata[24] !== want.applied)
					report_mismatch("press_applied", m_tdata[24], want.applied);
				if (m_tdata[25] !== want.sat)
					report_mismatch("saturated", m_tdata[25], want.sat);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[23:0];
		case (idx)
			CFG_ENABLED: ripple_on = value[0];
			CFG_BLUR:    blur_q16 = value & 32'hFFFF;
			default:     stamp_height = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		do @(posedge clk);
		while (request_q.size() != 0 || s_tvalid || answer_q.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic void add_tick(int dt, bit pressed, int px, int py);
		request_t rq;
		rq.op = OP_TICK;
		rq.dt = dt[15:0];
		rq.pressed = pressed;
		rq.px = px[9:0];
		rq.py = py[9:0];
		rq.rr = $urandom;
		rq.rc = $urandom;
		request_q.push_back(rq);
	endfunction

	function automatic void add_read(int r, int c);
		request_t rq;
		rq.op = OP_READ;
		rq.dt = $urandom;
		rq.pressed = $urandom;
		rq.px = $urandom;
		rq.py = $urandom;
		rq.rr = r[5:0];
		rq.rc = c[5:0];
		request_q.push_back(rq);
	endfunction

	initial begin
		int tick_odds;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_data = '0;
		mismatch_count = 0;
		answers_seen = 0;
		burst_left = 4;
		gap_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		stall_mode_left = 0;
		stall_mode = 1'b0;
		ripple_on = 1'b0;
		blur_q16 = 983;
		stamp_height = -7680;
		foreach (wave_h[k]) begin
			wave_h[k] = 0;
			wave_v[k] = 0;
			wave_lap[k] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// frozen grid: reads and a pressed tick that must do nothing
		add_read(0, 0);
		add_read(63, 63);
		add_tick(65535, 1, 512, 512);
		add_read(32, 32);
		drain();

		write_reg(CFG_ENABLED, 1);
		add_tick(0, 1, 17, 500);       // column 1, just outside the press bounds
		add_tick(65535, 1, 512, 512);
		add_tick(40000, 1, 992, 992);  // cell 61, last whose full patch is stamped, patch touches the border
		add_read(61, 61);
		add_read(62, 62);
		add_read(32, 31);
		add_tick(30000, 1, 1023, 1023); // maps to column 62, accepted, patch clipped at the border
		add_tick(1000, 0, 0, 0);
		add_read(33, 33);
		drain();

		write_reg(CFG_PRESS, VMAX);
		write_reg(CFG_BLUR, 65535);
		add_tick(65535, 1, 300, 700);   // drives the laplacian into clipping
		add_read(21, 9);
		add_read(20, 9);
		drain();

		write_reg(CFG_PRESS, VMIN);
		write_reg(CFG_BLUR, 0);
		add_tick(32768, 1, 33, 33);     // lowest stampable cell
		add_read(2, 2);
		add_read(1, 1);
		drain();

		for (int seg = 0; seg < 4; seg++) begin
			write_reg(CFG_ENABLED, (seg % 2 == 0) ? 1 : $urandom_range(0, 1));
			write_reg(CFG_BLUR, $urandom_range(0, 65535));
			write_reg(CFG_PRESS, int'($urandom_range(0, 32'hFFFFFF) << 8) >>> 8);
			tick_odds = ripple_on ? 6 : 2;
			for (int n = 0; n < 20; n++) begin
				if ($urandom_range(1, tick_odds) == 1)
					add_tick($urandom_range(0, 65535), $urandom_range(0, 1),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					add_read($urandom_range(0, 63), $urandom_range(0, 63));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/rwgs_pkg.sv
rtl/rwgs_ram.sv
rtl/rwgs_datapath.sv
rtl/rwgs_ctrl.sv
rtl/water_ripple_grid_step_unit.sv
bench/tb_water_ripple_grid_step_unit.sv
